>>> rtl/hd1d_pkg.sv
`timescale 1ns / 1ps

package hd1d_pkg;

	// grid word width, Q3.28
	localparam int VW = 32;

	localparam logic [1:0] SCH_EXPL = 2'd0;
	localparam logic [1:0] SCH_IMPL = 2'd1;
	localparam logic [1:0] SCH_CN   = 2'd2;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] REG_SCHEME = 2'd0;
	localparam logic [1:0] REG_ALPHA  = 2'd1;
	localparam logic [1:0] REG_GPTS   = 2'd2;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [4:0] {
		OP_NOP, OP_CLR_FAULT, OP_LOAD_CUR, OP_LOAD_NXT, OP_MUL_DIFF, OP_POST_STEN,
		OP_TH_INIT, OP_LOAD_R, OP_DIV_START, OP_DIV_STEP, OP_MUL_AQ, OP_POST_C,
		OP_MUL_RC, OP_POST_R, OP_MUL_AC, OP_POST_M, OP_MUL_RQ, OP_POST_X,
		OP_LOAD_BK, OP_MUL_AX, OP_POST_T, OP_OUT_READ, OP_OUT_STEP
	} dp_op_t;

	typedef enum logic [1:0] {GW_ZERO, GW_VALUE, GW_POST} gw_sel_t;

	typedef struct packed {
		dp_op_t  op;
		logic    grid_we;
		logic    grid_re;
		logic    rhs_we;
		logic    rhs_re;
		logic    piv_we;
		logic    piv_re;
		gw_sel_t gw_sel;
		logic    rw_post;
		logic    flag;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_full;
	} dp_stat_t;

endpackage

>>> rtl/heat_diffusion_1d_stepper_top.sv
`timescale 1ns / 1ps
// A write lands in the grid memory on acceptance; a read's word is registered in the
// memory, then in the output register once that is free. A time step runs a stencil
// pass (explicit), a tridiagonal solve (implicit) or both (Crank-Nicolson).
// One command is worked at a time; s_tready is high only while the sequencer is idle.
// Reset: asynchronous, active low; afterwards the grid memory is swept to zero
// a point at a time, during which no word is taken (configuration writes are).

module heat_diffusion_1d_stepper_top #(
	parameter int MAX_POINTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // cmd[1:0], index[12:2], value[44:13], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // data[31:0], fault[32], zero fill
	output logic        m_tuser,   // kind
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS+1);

	// configuration registers
	logic [1:0]  scheme_q;
	logic [31:0] alpha_q;
	logic [10:0] gpts_q;
	logic [CW-1:0] n;

	hd1d_pkg::dp_cmd_t  cmd;
	hd1d_pkg::dp_stat_t stat;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0] out_data;
	logic out_fault, out_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q <= hd1d_pkg::SCH_CN;
			alpha_q  <= 32'd32768;
			gpts_q   <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hd1d_pkg::REG_SCHEME: scheme_q <= cfg_data[1:0];
				hd1d_pkg::REG_ALPHA:  alpha_q  <= cfg_data;
				hd1d_pkg::REG_GPTS:   gpts_q   <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	// points in use, held to the memory depth
	always_comb begin
		if (32'(gpts_q) > 32'(MAX_POINTS)) n = CW'(MAX_POINTS);
		else n = CW'(gpts_q);
	end

	hd1d_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_cmd(s_tdata[1:0]), .in_idx(s_tdata[12:2]),
		.n(n), .scheme(scheme_q), .stat(stat), .cmd(cmd),
		.rd_addr(rd_addr), .wr_addr(wr_addr)
	);

	hd1d_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.rd_addr(rd_addr), .wr_addr(wr_addr),
		.scheme(scheme_q), .alpha(alpha_q), .wr_value(s_tdata[44:13]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_kind(out_kind), .out_data(out_data), .out_fault(out_fault)
	);

	assign m_tdata = {7'd0, out_fault, out_data};
	assign m_tuser = out_kind;

endmodule

>>> rtl/hd1d_ram.sv
`timescale 1ns / 1ps

module hd1d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/hd1d_dp.sv
`timescale 1ns / 1ps

module hd1d_dp #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hd1d_pkg::dp_cmd_t             cmd,
	output hd1d_pkg::dp_stat_t            stat,
	input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
	input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
	input  logic [1:0]                    scheme,
	input  logic [31:0]                   alpha,
	input  logic [31:0]                   wr_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_kind,
	output logic [31:0]                   out_data,
	output logic                          out_fault
);

	localparam int VW = hd1d_pkg::VW;

	logic [VW-1:0] grid_rd, rhs_rd, piv_rd;
	logic [VW-1:0] grid_wd, rhs_wd;

	logic signed [VW-1:0] prev_q, cur_q, nxt_q, r_q, x_q;
	logic [33:0] d_q, m_q, dvs_q;
	logic [16:0] c_q;
	logic [31:0] q_q;
	logic [34:0] rem_q;
	logic [4:0]  cnt_q;
	logic signed [67:0] prod_s1;
	logic fault_q;
	logic out_valid_q, out_kind_q, out_fault_q;
	logic [31:0] out_data_q;

	logic signed [34:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [34:0] diff;
	logic signed [69:0] prod70, rnd16, rnd31, addend, sum;
	logic sat_hit, use31;
	logic signed [VW-1:0] post_val;
	logic [VW-1:0] src_rd;
	logic [35:0] rem2;
	logic ge;

	hd1d_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_grid (
		.clk(clk), .we(cmd.grid_we), .waddr(wr_addr), .wdata(grid_wd),
		.re(cmd.grid_re), .raddr(rd_addr), .rdata(grid_rd)
	);

	hd1d_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_rhs (
		.clk(clk), .we(cmd.rhs_we), .waddr(wr_addr), .wdata(rhs_wd),
		.re(cmd.rhs_re), .raddr(rd_addr), .rdata(rhs_rd)
	);

	hd1d_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_piv (
		.clk(clk), .we(cmd.piv_we), .waddr(wr_addr), .wdata(q_q),
		.re(cmd.piv_re), .raddr(rd_addr), .rdata(piv_rd)
	);

	assign src_rd = (scheme == hd1d_pkg::SCH_IMPL) ? grid_rd : rhs_rd;
	assign diff   = 35'(prev_q) + 35'(nxt_q) - (35'(cur_q) <<< 1);

	// shared multiplier operands
	always_comb begin
		mul_a = 35'(diff);
		mul_b = $signed({1'b0, alpha});
		case (cmd.op)
			hd1d_pkg::OP_MUL_AQ: begin
				mul_a = $signed({3'b0, alpha});
				mul_b = $signed({1'b0, q_q});
			end
			hd1d_pkg::OP_MUL_RC: begin
				mul_a = 35'(r_q);
				mul_b = $signed({16'b0, c_q});
			end
			hd1d_pkg::OP_MUL_AC: begin
				mul_a = $signed({3'b0, alpha});
				mul_b = $signed({16'b0, c_q});
			end
			hd1d_pkg::OP_MUL_RQ: begin
				mul_a = 35'(r_q);
				mul_b = $signed({1'b0, q_q});
			end
			hd1d_pkg::OP_MUL_AX: begin
				mul_a = 35'(x_q);
				mul_b = $signed({1'b0, alpha});
			end
			default: begin
			end
		endcase
	end

	// round half up, add, saturate
	always_comb begin
		prod70 = 70'(prod_s1);
		rnd16  = (prod70 + 70'sd32768) >>> 16;
		rnd31  = (prod70 + 70'sd1073741824) >>> 31;
		use31  = (cmd.op == hd1d_pkg::OP_POST_X) || (cmd.op == hd1d_pkg::OP_POST_C);
		case (cmd.op)
			hd1d_pkg::OP_POST_STEN: addend = (scheme == hd1d_pkg::SCH_CN) ?
				(70'(cur_q) <<< 1) : 70'(cur_q);
			hd1d_pkg::OP_POST_R, hd1d_pkg::OP_POST_T: addend = 70'(nxt_q);
			default: addend = '0;
		endcase
		sum      = (use31 ? rnd31 : rnd16) + addend;
		sat_hit  = !((&sum[69:31]) || (~|sum[69:31]));
		post_val = sat_hit ? (sum[69] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
			: sum[VW-1:0];
	end

	always_comb begin
		case (cmd.gw_sel)
			hd1d_pkg::GW_ZERO:  grid_wd = '0;
			hd1d_pkg::GW_VALUE: grid_wd = wr_value;
			default:            grid_wd = post_val;
		endcase
		rhs_wd = cmd.rw_post ? post_val : r_q;
	end

	// restoring divide of 2^47 by the pivot, one quotient bit a cycle
	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {2'b0, dvs_q};

	assign stat.div_last = (cnt_q == 5'd31);
	assign stat.out_full = out_valid_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			hd1d_pkg::OP_LOAD_CUR: begin
				cur_q  <= grid_rd;
				prev_q <= '0;
			end
			hd1d_pkg::OP_LOAD_NXT: nxt_q <= cmd.flag ? '0 : grid_rd;
			hd1d_pkg::OP_POST_STEN: begin
				prev_q <= cur_q;
				cur_q  <= nxt_q;
			end
			hd1d_pkg::OP_TH_INIT: begin
				d_q <= ((scheme == hd1d_pkg::SCH_CN) ? 34'd131072 : 34'd65536)
					+ {1'b0, alpha, 1'b0};
				m_q <= ((scheme == hd1d_pkg::SCH_CN) ? 34'd131072 : 34'd65536)
					+ {1'b0, alpha, 1'b0};
			end
			hd1d_pkg::OP_LOAD_R: r_q <= src_rd;
			hd1d_pkg::OP_DIV_START: begin
				rem_q <= 35'd32768;
				dvs_q <= (m_q < 34'd65536) ? 34'd65536 : m_q;
			end
			hd1d_pkg::OP_DIV_STEP: begin
				rem_q <= ge ? 35'(rem2 - {2'b0, dvs_q}) : rem2[34:0];
				q_q   <= {q_q[30:0], ge};
			end
			hd1d_pkg::OP_POST_C: begin
				c_q   <= (rnd31 > 70'sd65536) ? 17'd65536 : rnd31[16:0];
				nxt_q <= src_rd;
			end
			hd1d_pkg::OP_POST_R: r_q <= post_val;
			hd1d_pkg::OP_POST_M: m_q <= d_q - rnd16[33:0];
			hd1d_pkg::OP_POST_X: x_q <= post_val;
			hd1d_pkg::OP_LOAD_BK: begin
				nxt_q <= rhs_rd;
				q_q   <= piv_rd;
			end
			hd1d_pkg::OP_POST_T: r_q <= post_val;
			hd1d_pkg::OP_MUL_DIFF, hd1d_pkg::OP_MUL_AQ, hd1d_pkg::OP_MUL_RC,
			hd1d_pkg::OP_MUL_AC, hd1d_pkg::OP_MUL_RQ, hd1d_pkg::OP_MUL_AX:
				prod_s1 <= mul_a * mul_b;
			default: begin
			end
		endcase
		if (cmd.op == hd1d_pkg::OP_OUT_READ) begin
			out_kind_q  <= hd1d_pkg::KIND_READ;
			out_data_q  <= cmd.flag ? grid_rd : '0;
			out_fault_q <= !cmd.flag;
		end else if (cmd.op == hd1d_pkg::OP_OUT_STEP) begin
			out_kind_q  <= hd1d_pkg::KIND_DONE;
			out_data_q  <= '0;
			out_fault_q <= fault_q | cmd.flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				hd1d_pkg::OP_CLR_FAULT: fault_q <= 1'b0;
				hd1d_pkg::OP_POST_STEN, hd1d_pkg::OP_POST_R,
				hd1d_pkg::OP_POST_X, hd1d_pkg::OP_POST_T: fault_q <= fault_q | sat_hit;
				default: begin
				end
			endcase
			if (cmd.op == hd1d_pkg::OP_DIV_START) begin
				cnt_q <= '0;
			end else if (cmd.op == hd1d_pkg::OP_DIV_STEP) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (cmd.op == hd1d_pkg::OP_OUT_READ || cmd.op == hd1d_pkg::OP_OUT_STEP) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_data  = out_data_q;
	assign out_fault = out_fault_q;

endmodule

>>> rtl/hd1d_ctrl.sv
`timescale 1ns / 1ps

module hd1d_ctrl #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      in_cmd,
	input  logic [10:0]                     in_idx,
	input  logic [$clog2(MAX_POINTS+1)-1:0] n,
	input  logic [1:0]                      scheme,
	input  hd1d_pkg::dp_stat_t              stat,
	output hd1d_pkg::dp_cmd_t               cmd,
	output logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
	output logic [$clog2(MAX_POINTS)-1:0]   wr_addr
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS+1);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RD_OUT, S_STEP,
		S_ST_RD0, S_ST_LD0, S_ST_RDN, S_ST_LDN, S_ST_MUL, S_ST_POST,
		S_TH_INIT, S_TH_LD0, S_TH_DIV0, S_TH_DIV, S_TH_PIV, S_TH_C,
		S_TH_MRC, S_TH_R, S_TH_MAC, S_TH_M,
		S_BK_MUL0, S_BK_X, S_BK_RD, S_BK_LD, S_BK_MAX, S_BK_T, S_BK_MRQ,
		S_DONE
	} state_t;

	state_t state_q;
	logic [CW-1:0] i_q;
	logic ok_q, bad_q;
	logic idx_ok, accept, last;
	logic [CW-1:0] i_nx;

	assign idx_ok   = (in_idx != 11'd0) && (32'(in_idx) <= 32'(n));
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign i_nx     = i_q + CW'(1);
	assign last     = (i_nx == n);

	always_comb begin
		cmd     = '{op: hd1d_pkg::OP_NOP, gw_sel: hd1d_pkg::GW_POST, default: 1'b0};
		rd_addr = i_q[AW-1:0];
		wr_addr = i_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				cmd.grid_we = 1'b1;
				cmd.gw_sel  = hd1d_pkg::GW_ZERO;
			end
			S_IDLE: begin
				rd_addr = AW'(in_idx - 11'd1);
				wr_addr = AW'(in_idx - 11'd1);
				cmd.gw_sel  = hd1d_pkg::GW_VALUE;
				cmd.grid_we = accept && (in_cmd == hd1d_pkg::CMD_WRITE) && idx_ok;
				cmd.grid_re = accept && (in_cmd == hd1d_pkg::CMD_READ) && idx_ok;
			end
			S_RD_OUT: begin
				cmd.flag = ok_q;
				if (!stat.out_full) cmd.op = hd1d_pkg::OP_OUT_READ;
			end
			S_STEP:   cmd.op = hd1d_pkg::OP_CLR_FAULT;
			S_ST_RD0: cmd.grid_re = 1'b1;
			S_ST_LD0: cmd.op = hd1d_pkg::OP_LOAD_CUR;
			S_ST_RDN: begin
				rd_addr     = i_nx[AW-1:0];
				cmd.grid_re = !last;
			end
			S_ST_LDN: begin
				cmd.op   = hd1d_pkg::OP_LOAD_NXT;
				cmd.flag = last;
			end
			S_ST_MUL: cmd.op = hd1d_pkg::OP_MUL_DIFF;
			S_ST_POST: begin
				cmd.op      = hd1d_pkg::OP_POST_STEN;
				cmd.grid_we = (scheme == hd1d_pkg::SCH_EXPL);
				cmd.rhs_we  = (scheme != hd1d_pkg::SCH_EXPL);
				cmd.rw_post = 1'b1;
			end
			S_TH_INIT: begin
				cmd.op      = hd1d_pkg::OP_TH_INIT;
				rd_addr     = '0;
				cmd.grid_re = (scheme == hd1d_pkg::SCH_IMPL);
				cmd.rhs_re  = (scheme != hd1d_pkg::SCH_IMPL);
			end
			S_TH_LD0: cmd.op = hd1d_pkg::OP_LOAD_R;
			S_TH_DIV0: begin
				cmd.op     = hd1d_pkg::OP_DIV_START;
				cmd.rhs_we = 1'b1;
			end
			S_TH_DIV: cmd.op = hd1d_pkg::OP_DIV_STEP;
			S_TH_PIV: begin
				cmd.piv_we = 1'b1;
				rd_addr    = i_nx[AW-1:0];
				if (!last) begin
					cmd.op      = hd1d_pkg::OP_MUL_AQ;
					cmd.grid_re = (scheme == hd1d_pkg::SCH_IMPL);
					cmd.rhs_re  = (scheme != hd1d_pkg::SCH_IMPL);
				end
			end
			S_TH_C:    cmd.op = hd1d_pkg::OP_POST_C;
			S_TH_MRC:  cmd.op = hd1d_pkg::OP_MUL_RC;
			S_TH_R:    cmd.op = hd1d_pkg::OP_POST_R;
			S_TH_MAC:  cmd.op = hd1d_pkg::OP_MUL_AC;
			S_TH_M:    cmd.op = hd1d_pkg::OP_POST_M;
			S_BK_MUL0: cmd.op = hd1d_pkg::OP_MUL_RQ;
			S_BK_X: begin
				cmd.op      = hd1d_pkg::OP_POST_X;
				cmd.grid_we = 1'b1;
			end
			S_BK_RD: begin
				cmd.rhs_re = 1'b1;
				cmd.piv_re = 1'b1;
			end
			S_BK_LD:  cmd.op = hd1d_pkg::OP_LOAD_BK;
			S_BK_MAX: cmd.op = hd1d_pkg::OP_MUL_AX;
			S_BK_T:   cmd.op = hd1d_pkg::OP_POST_T;
			S_BK_MRQ: cmd.op = hd1d_pkg::OP_MUL_RQ;
			S_DONE: begin
				cmd.flag = bad_q;
				if (!stat.out_full) cmd.op = hd1d_pkg::OP_OUT_STEP;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			i_q     <= '0;
			ok_q    <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					i_q <= i_nx;
					if (i_q == CW'(MAX_POINTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						ok_q <= idx_ok;
						if (in_cmd == hd1d_pkg::CMD_READ) state_q <= S_RD_OUT;
						else if (in_cmd == hd1d_pkg::CMD_RUN) state_q <= S_STEP;
					end
				end
				S_RD_OUT: if (!stat.out_full) state_q <= S_IDLE;
				S_STEP: begin
					i_q   <= '0;
					bad_q <= (scheme == 2'd3);
					if (scheme == 2'd3 || n == '0) state_q <= S_DONE;
					else if (scheme == hd1d_pkg::SCH_IMPL) state_q <= S_TH_INIT;
					else state_q <= S_ST_RD0;
				end
				S_ST_RD0: state_q <= S_ST_LD0;
				S_ST_LD0: state_q <= S_ST_RDN;
				S_ST_RDN: state_q <= S_ST_LDN;
				S_ST_LDN: state_q <= S_ST_MUL;
				S_ST_MUL: state_q <= S_ST_POST;
				S_ST_POST: begin
					if (last) begin
						i_q     <= '0;
						state_q <= (scheme == hd1d_pkg::SCH_EXPL) ? S_DONE : S_TH_INIT;
					end else begin
						i_q     <= i_nx;
						state_q <= S_ST_RDN;
					end
				end
				S_TH_INIT: state_q <= S_TH_LD0;
				S_TH_LD0:  state_q <= S_TH_DIV0;
				S_TH_DIV0: state_q <= S_TH_DIV;
				S_TH_DIV:  if (stat.div_last) state_q <= S_TH_PIV;
				S_TH_PIV:  state_q <= last ? S_BK_MUL0 : S_TH_C;
				S_TH_C:    state_q <= S_TH_MRC;
				S_TH_MRC:  state_q <= S_TH_R;
				S_TH_R:    state_q <= S_TH_MAC;
				S_TH_MAC:  state_q <= S_TH_M;
				S_TH_M: begin
					i_q     <= i_nx;
					state_q <= S_TH_DIV0;
				end
				S_BK_MUL0: state_q <= S_BK_X;
				S_BK_X: begin
					if (i_q == '0) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q - CW'(1);
						state_q <= S_BK_RD;
					end
				end
				S_BK_RD:  state_q <= S_BK_LD;
				S_BK_LD:  state_q <= S_BK_MAX;
				S_BK_MAX: state_q <= S_BK_T;
				S_BK_T:   state_q <= S_BK_MRQ;
				S_BK_MRQ: state_q <= S_BK_X;
				S_DONE:   if (!stat.out_full) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> sim/heat_diffusion_1d_stepper_top_tb.sv
`timescale 1ns / 1ps

module heat_diffusion_1d_stepper_top_tb;

	localparam int NPTS = 1024;
	localparam logic signed [127:0] VMAX = 128'sd2147483647;
	localparam logic signed [127:0] VMIN = -128'sd2147483648;

	typedef struct {
		logic [1:0]  cmd;
		logic [10:0] index;
		logic [31:0] value;
		int          gap;
	} grid_cmd_t;

	typedef struct {
		logic        kind;
		logic [31:0] data;
		logic        fault;
	} grid_resp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // cmd[1:0], index[12:2], value[44:13], zero fill
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // data[31:0], fault[32], zero fill
	logic        m_tuser;   // kind
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	heat_diffusion_1d_stepper_top #(.MAX_POINTS(NPTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the block's state and registers
	logic signed [31:0] grid_mirror [NPTS];
	logic signed [31:0] rhs_mirror [NPTS];
	longint unsigned    pivot_mirror [NPTS];
	logic [1:0]         scheme_r;
	longint unsigned    alpha_r;
	int                 gpts_r;
	bit                 step_fault;

	grid_cmd_t  cmd_pending[$];
	grid_resp_t resp_expected[$];
	int         mismatches;
	bit         rx_idle_on;   // receiver draws random stalls when set
	bit         rx_hold_req;  // ask the receiver for one long hold-off

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Saturate a wide value to Q3.28 and note the saturation
	function automatic logic signed [31:0] sat_q328(logic signed [127:0] a);
		if (a > VMAX) begin
			step_fault = 1'b1;
			return 32'sh7fffffff;
		end
		if (a < VMIN) begin
			step_fault = 1'b1;
			return 32'sh80000000;
		end
		return a[31:0];
	endfunction

	// Exact product, rounding right shift (half up), add, saturate
	function automatic logic signed [31:0] scale_q(logic signed [63:0] v, longint unsigned f,
			int sh, logic signed [63:0] addend);
		logic signed [127:0] p;
		logic signed [127:0] fw;
		logic signed [127:0] aw;
		p = v;
		fw = {64'd0, f};
		aw = addend;
		p = p * fw;
		p = (p + (128'sd1 <<< (sh - 1))) >>> sh;
		return sat_q328(p + aw);
	endfunction

	function automatic void stencil_pass(int n, bit cn);
		logic signed [63:0] prev;
		logic signed [63:0] c;
		logic signed [63:0] r;
		logic signed [31:0] v;
		prev = 0;
		for (int i = 0; i < n; i++) begin
			c = grid_mirror[i];
			r = (i + 1 < n) ? 64'(grid_mirror[i + 1]) : 64'sd0;
			v = scale_q(prev + r - 2 * c, alpha_r, 16, cn ? 2 * c : c);
			if (cn)
				rhs_mirror[i] = v;
			else
				grid_mirror[i] = v;
			prev = c;
		end
	endfunction

	function automatic void tridiag_solve(int n, longint unsigned k);
		longint unsigned d;
		longint unsigned m;
		longint unsigned inv;
		longint unsigned c;
		logic signed [31:0] x;
		logic signed [31:0] t;
		d = (k << 16) + 2 * alpha_r;
		m = d;
		for (int i = 0; i < n; i++) begin
			if (m < 65536) m = 65536;
			inv = (64'd1 << 47) / m;
			pivot_mirror[i] = inv;
			if (i + 1 < n) begin
				c = (alpha_r * inv + (64'd1 << 30)) >> 31;
				if (c > 65536) c = 65536;
				rhs_mirror[i + 1] = scale_q(rhs_mirror[i], c, 16, rhs_mirror[i + 1]);
				m = d - ((alpha_r * c + 32768) >> 16);
			end
		end
		x = scale_q(rhs_mirror[n - 1], pivot_mirror[n - 1], 31, 0);
		grid_mirror[n - 1] = x;
		for (int i = n - 1; i > 0; i--) begin
			t = scale_q(x, alpha_r, 16, rhs_mirror[i - 1]);
			x = scale_q(t, pivot_mirror[i - 1], 31, 0);
			grid_mirror[i - 1] = x;
		end
	endfunction

	// Work out what one accepted word does to the grid and what it returns
	function automatic void predict_grid_cmd(grid_cmd_t w);
		int n;
		bit in_range;
		grid_resp_t e;
		n = (gpts_r > NPTS) ? NPTS : gpts_r;
		in_range = (w.index >= 1) && (w.index <= n);
		step_fault = 1'b0;
		case (w.cmd)
			hd1d_pkg::CMD_WRITE: begin
				if (in_range) grid_mirror[w.index - 1] = w.value;
			end
			hd1d_pkg::CMD_RUN: begin
				if (scheme_r == 2'd3) begin
					step_fault = 1'b1;
				end else if (n > 0) begin
					if (scheme_r == hd1d_pkg::SCH_EXPL) begin
						stencil_pass(n, 1'b0);
					end else if (scheme_r == hd1d_pkg::SCH_IMPL) begin
						for (int i = 0; i < n; i++) rhs_mirror[i] = grid_mirror[i];
						tridiag_solve(n, 1);
					end else begin
						stencil_pass(n, 1'b1);
						tridiag_solve(n, 2);
					end
				end
				e.kind = hd1d_pkg::KIND_DONE;
				e.data = '0;
				e.fault = step_fault;
				resp_expected.push_back(e);
			end
			hd1d_pkg::CMD_READ: begin
				e.kind = hd1d_pkg::KIND_READ;
				e.data = in_range ? grid_mirror[w.index - 1] : '0;
				e.fault = !in_range;
				resp_expected.push_back(e);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Driver: offer queued words, honour each word's gap
	int gap_cnt;
	always @(posedge clk) begin
		bit nv;
		grid_cmd_t w;
		if (arst_n) begin
			nv = s_tvalid;
			if (s_tvalid && s_tready) nv = 1'b0;
			if (!nv && cmd_pending.size() > 0) begin
				if (gap_cnt < cmd_pending[0].gap) begin
					gap_cnt++;
				end else begin
					w = cmd_pending.pop_front();
					gap_cnt = 0;
					predict_grid_cmd(w);
					s_tdata <= {3'b0, w.value, w.index, w.cmd};
					nv = 1'b1;
				end
			end
			s_tvalid <= nv;
		end
	end

	// Monitor: stall at random, hold off on request, check every word taken
	int stall_cnt;
	int hold_cnt;
	always @(posedge clk) begin
		grid_resp_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (resp_expected.size() == 0) begin
					report_mismatch("unexpected word", m_tdata[31:0], '0);
				end else begin
					e = resp_expected.pop_front();
					if (m_tuser !== e.kind) report_mismatch("kind", m_tuser, e.kind);
					if (m_tdata[31:0] !== e.data) report_mismatch("data", m_tdata[31:0], e.data);
					if (m_tdata[32] !== e.fault) report_mismatch("fault", m_tdata[32], e.fault);
				end
				stall_cnt = rx_idle_on ? $urandom_range(0, 15) : 0;
			end
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_cnt = 300;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			hd1d_pkg::REG_SCHEME: scheme_r = val[1:0];
			hd1d_pkg::REG_ALPHA:  alpha_r = val;
			hd1d_pkg::REG_GPTS:   gpts_r = val[10:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_cmd(logic [1:0] cmd, logic [10:0] idx, logic [31:0] val, bit idle);
		grid_cmd_t w;
		w.cmd = cmd;
		w.index = idx;
		w.value = val;
		w.gap = idle ? $urandom_range(0, 15) : 0;
		cmd_pending.push_back(w);
	endtask

	// Hold until every word is sent and answered, then let a write settle
	task automatic drain;
		while (cmd_pending.size() > 0 || s_tvalid || resp_expected.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(0, 32'h20000000) - 32'h10000000;
		endcase
	endfunction

	// Mostly well-formed traffic for the current grid size, some noise
	task automatic random_phase(int count, bit idle);
		int n;
		int r;
		n = (gpts_r > NPTS) ? NPTS : gpts_r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (n == 0 || r >= 85)
				push_cmd($urandom_range(0, 3), $urandom_range(0, 2047), $urandom(), idle);
			else if (r < 45)
				push_cmd(hd1d_pkg::CMD_WRITE, $urandom_range(1, n), rand_value(), idle);
			else if (r < 68)
				push_cmd(hd1d_pkg::CMD_READ, $urandom_range(1, n), $urandom(), idle);
			else
				push_cmd(hd1d_pkg::CMD_RUN, $urandom_range(0, 2047), $urandom(), idle);
		end
	endtask

	initial begin
		logic [31:0] a;
		int np;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		mismatches = 0;
		gap_cnt = 0;
		stall_cnt = 0;
		hold_cnt = 0;
		rx_idle_on = 1'b1;
		rx_hold_req = 1'b0;
		for (int i = 0; i < NPTS; i++) begin
			grid_mirror[i] = '0;
			rhs_mirror[i] = '0;
			pivot_mirror[i] = 0;
		end
		scheme_r = hd1d_pkg::SCH_CN;
		alpha_r = 32768;
		gpts_r = 1024;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: range edges, ignored commands, then a small ramp stepped by each scheme
		push_cmd(hd1d_pkg::CMD_READ, 0, 0, 1);
		push_cmd(hd1d_pkg::CMD_READ, 1, 0, 0);
		push_cmd(hd1d_pkg::CMD_READ, 1025, 0, 1);
		push_cmd(hd1d_pkg::CMD_READ, 2047, 0, 0);
		push_cmd(hd1d_pkg::CMD_WRITE, 1, 32'h7fffffff, 0);
		push_cmd(hd1d_pkg::CMD_WRITE, 1024, 32'h80000000, 1);
		push_cmd(hd1d_pkg::CMD_WRITE, 0, 32'h12345678, 0);
		push_cmd(hd1d_pkg::CMD_WRITE, 1025, 32'h12345678, 0);
		push_cmd(2'd3, 11'h7ff, 32'hffffffff, 0);
		push_cmd(hd1d_pkg::CMD_READ, 1, 0, 0);
		push_cmd(hd1d_pkg::CMD_READ, 1024, 0, 0);
		drain();
		cfg_write(hd1d_pkg::REG_GPTS, 4);
		cfg_write(hd1d_pkg::REG_SCHEME, hd1d_pkg::SCH_EXPL);
		for (int i = 1; i <= 4; i++) push_cmd(hd1d_pkg::CMD_WRITE, i, (i - 1) << 28, 0);
		push_cmd(hd1d_pkg::CMD_RUN, 0, 0, 0);
		push_cmd(hd1d_pkg::CMD_READ, 2, 0, 0);
		drain();
		cfg_write(hd1d_pkg::REG_SCHEME, hd1d_pkg::SCH_IMPL);
		push_cmd(hd1d_pkg::CMD_RUN, 0, 0, 1);
		push_cmd(hd1d_pkg::CMD_READ, 3, 0, 0);
		drain();
		cfg_write(hd1d_pkg::REG_SCHEME, hd1d_pkg::SCH_CN);
		push_cmd(hd1d_pkg::CMD_RUN, 0, 0, 0);
		push_cmd(hd1d_pkg::CMD_READ, 4, 0, 0);
		drain();
		cfg_write(hd1d_pkg::REG_SCHEME, 2'd3);
		push_cmd(hd1d_pkg::CMD_RUN, 0, 0, 0);
		drain();
		cfg_write(hd1d_pkg::REG_GPTS, 0);
		cfg_write(hd1d_pkg::REG_SCHEME, hd1d_pkg::SCH_CN);
		push_cmd(hd1d_pkg::CMD_RUN, 0, 0, 0);
		push_cmd(hd1d_pkg::CMD_READ, 1, 0, 0);
		drain();

		// Random phases over schemes, alphas and grid sizes
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 4)
				0: a = 32'h0;
				1: a = 32'hffffffff;
				2: a = $urandom_range(0, 32'h20000);
				default: a = $urandom();
			endcase
			if (ph == 1)
				np = 2047;
			else if (ph < 5)
				np = ph;
			else
				np = $urandom_range(1, 16);
			cfg_write(hd1d_pkg::REG_SCHEME, (ph < 8) ? ph % 3 : $urandom_range(0, 3));
			cfg_write(hd1d_pkg::REG_ALPHA, a);
			cfg_write(hd1d_pkg::REG_GPTS, np);
			rx_idle_on = ph % 3 != 2;
			if (np == 2047) begin
				push_cmd(hd1d_pkg::CMD_WRITE, 1, rand_value(), 1);
				push_cmd(hd1d_pkg::CMD_WRITE, 512, rand_value(), 0);
				push_cmd(hd1d_pkg::CMD_WRITE, 1024, rand_value(), 0);
				push_cmd(hd1d_pkg::CMD_RUN, 0, 0, 0);
				push_cmd(hd1d_pkg::CMD_READ, 2, 0, 0);
				push_cmd(hd1d_pkg::CMD_READ, 1023, 0, 1);
				push_cmd(hd1d_pkg::CMD_READ, 1024, 0, 0);
			end else begin
				random_phase(8, ph % 2 == 0);
			end
			if (ph == 6) begin
				// Receiver holds off while reads pile up against the block
				rx_hold_req = 1'b1;
				for (int k = 0; k < 6; k++)
					push_cmd(hd1d_pkg::CMD_READ, $urandom_range(1, np), 0, 0);
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
